@@ hw/rtl/hte_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_pkg
// Shared types, constants and name-compare helpers for the HTML text
// extractor.
// ----------------------------------------------------------------------------
package hte_pkg;

  localparam int TagStoreLen    = 128;
  localparam int MatchPrefixLen = 10;
  localparam int TagLenW        = $clog2(TagStoreLen);
  localparam int PfxIdxW        = $clog2(MatchPrefixLen);
  localparam int TagLenMax      = TagStoreLen - 1;
  localparam int LimitW         = 17;
  localparam int CountW         = 16;
  localparam logic [LimitW-1:0] LimitReset = 17'd24576;
  localparam logic [LimitW-1:0] LimitCap   = 17'h10000;

  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSlash = 8'h2F;

  // Names are left-justified in eight bytes; the first character sits on top.
  localparam logic [63:0] NmScript  = {"script", 16'h0};
  localparam logic [63:0] NmStyle   = {"style", 24'h0};
  localparam logic [63:0] NmNav     = {"nav", 40'h0};
  localparam logic [63:0] NmFooter  = {"footer", 16'h0};
  localparam logic [63:0] NmCScript = {"/script", 8'h0};
  localparam logic [63:0] NmCStyle  = {"/style", 16'h0};
  localparam logic [63:0] NmCNav    = {"/nav", 32'h0};
  localparam logic [63:0] NmCFooter = {"/footer", 8'h0};
  localparam logic [63:0] NmBr      = {"br", 48'h0};
  localparam logic [63:0] NmCP      = {"/p", 48'h0};
  localparam logic [63:0] NmCDiv    = {"/div", 32'h0};
  localparam logic [63:0] NmCH1     = {"/h1", 40'h0};
  localparam logic [63:0] NmCH2     = {"/h2", 40'h0};
  localparam logic [63:0] NmCH3     = {"/h3", 40'h0};
  localparam logic [63:0] NmCH4     = {"/h4", 40'h0};
  localparam logic [63:0] NmCLi     = {"/li", 40'h0};
  localparam logic [63:0] NmLi      = {"li", 48'h0};
  localparam logic [63:0] NmCTr     = {"/tr", 40'h0};

  typedef enum logic [0:0] {
    CfgPassthrough = 1'b0,
    CfgOutputLimit = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_document;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        out_char;
    logic [CountW-1:0] out_index;
  } out_item_t;

  typedef struct packed {
    logic              passthrough;
    logic [LimitW-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic op_script;
    logic op_style;
    logic op_nav;
    logic op_footer;
    logic cl_script;
    logic cl_style;
    logic cl_nav;
    logic cl_footer;
    logic brk;
  } tag_hits_t;

  typedef logic [MatchPrefixLen-1:0][7:0] prefix_t;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
    return r;
  endfunction

  // True when the stored tag reads '<', the name, then nothing more or one of
  // space, '>' or '/'. Names are at most eight characters long.
  function automatic logic tag_is(input prefix_t pfx, input logic [TagLenW-1:0] len,
                                  input logic [63:0] nm, input logic [3:0] n);
    logic ok;
    logic [7:0] nx;
    ok = (len >= TagLenW'({3'b0, n} + 7'd1)) && (pfx[0] == ChLt);
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) begin
        ok = ok && (lower_ascii(pfx[i + 1]) == nm[63 - 8 * i -: 8]);
      end
    end
    nx = pfx[PfxIdxW'(n + 4'd1)];
    if (len != TagLenW'({3'b0, n} + 7'd1)) begin
      ok = ok && (nx == ChSp || nx == ChGt || nx == ChSlash);
    end
    return ok;
  endfunction

endpackage

@@ hw/rtl/hte_tag_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_tag_match
// Compares the stored tag prefix against all known tag names in parallel.
// ----------------------------------------------------------------------------
module hte_tag_match (
  input  hte_pkg::prefix_t                 pfx_i,
  input  logic [hte_pkg::TagLenW-1:0]      len_i,
  output hte_pkg::tag_hits_t               hits_o
);

  always_comb begin
    hits_o.op_script = hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmScript, 4'd6);
    hits_o.op_style  = hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmStyle, 4'd5);
    hits_o.op_nav    = hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmNav, 4'd3);
    hits_o.op_footer = hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmFooter, 4'd6);
    hits_o.cl_script = hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmCScript, 4'd7);
    hits_o.cl_style  = hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmCStyle, 4'd6);
    hits_o.cl_nav    = hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmCNav, 4'd4);
    hits_o.cl_footer = hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmCFooter, 4'd7);
    hits_o.brk = hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmBr, 4'd2)
              || hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmCP, 4'd2)
              || hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmCDiv, 4'd4)
              || hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmCH1, 4'd3)
              || hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmCH2, 4'd3)
              || hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmCH3, 4'd3)
              || hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmCH4, 4'd3)
              || hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmCLi, 4'd3)
              || hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmLi, 4'd2)
              || hte_pkg::tag_is(pfx_i, len_i, hte_pkg::NmCTr, 4'd3);
  end

endmodule

@@ hw/rtl/hte_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_core
// Parse state and combinational next-state logic: one byte per step.
// ----------------------------------------------------------------------------
module hte_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  hte_pkg::in_item_t             item_i,
  input  hte_pkg::cfg_t                 cfg_i,
  output logic                          res_valid_o,
  output hte_pkg::out_item_t            res_o,
  output logic [hte_pkg::CountW-1:0]    count_o
);

  typedef struct packed {
    logic script;
    logic style;
    logic nav;
    logic footer;
  } skip_t;

  logic                          in_tag_q, in_tag_d, in_tag_c;
  logic [hte_pkg::TagLenW-1:0]   len_q, len_d, len_c, len_n;
  hte_pkg::prefix_t              pfx_q, pfx_d, pfx_n;
  skip_t                         skip_q, skip_d, skip_c;
  logic                          pws_q, pws_d, pws_c;
  logic                          pwn_q, pwn_d, pwn_c;
  logic [hte_pkg::CountW-1:0]    cnt_q, cnt_d, cnt_c;
  hte_pkg::tag_hits_t            hits;
  logic [hte_pkg::LimitW-1:0]    lim;
  logic                          can_emit, want_emit, emit_ok, tag_path;
  logic [7:0]                    ch, b;

  assign b = item_i.in_byte;

  // A new document clears the parse state before its first byte is handled.
  always_comb begin
    in_tag_c = in_tag_q;
    len_c    = len_q;
    skip_c   = skip_q;
    pws_c    = pws_q;
    pwn_c    = pwn_q;
    cnt_c    = cnt_q;
    if (item_i.new_document) begin
      in_tag_c = 1'b0;
      len_c    = '0;
      skip_c   = '0;
      pws_c    = 1'b1;
      pwn_c    = 1'b0;
      cnt_c    = '0;
    end
    tag_path = !cfg_i.passthrough && (in_tag_c || b == hte_pkg::ChLt);
    pfx_n = pfx_q;
    len_n = len_c;
    if (len_c < hte_pkg::TagLenW'(hte_pkg::TagLenMax)) begin
      if (len_c < hte_pkg::TagLenW'(hte_pkg::MatchPrefixLen)) begin
        pfx_n[len_c[hte_pkg::PfxIdxW-1:0]] = b;
      end
      len_n = len_c + 1'b1;
    end
  end

  hte_tag_match u_match (
    .pfx_i  (pfx_n),
    .len_i  (len_n),
    .hits_o (hits)
  );

  assign lim      = (cfg_i.limit > hte_pkg::LimitCap) ? hte_pkg::LimitCap : cfg_i.limit;
  assign can_emit = ({1'b0, cnt_c} + 17'd1) < lim;

  always_comb begin
    in_tag_d  = in_tag_c;
    len_d     = len_c;
    pfx_d     = pfx_q;
    skip_d    = skip_c;
    pws_d     = pws_c;
    want_emit = 1'b0;
    ch        = b;
    if (cfg_i.passthrough) begin
      want_emit = 1'b1;
    end else if (tag_path) begin
      in_tag_d = 1'b1;
      len_d    = len_n;
      pfx_d    = pfx_n;
      if (b != hte_pkg::ChGt) begin
        priority if (hits.op_script) skip_d.script = 1'b1;
        else if (hits.op_style)  skip_d.style  = 1'b1;
        else if (hits.op_nav)    skip_d.nav    = 1'b1;
        else if (hits.op_footer) skip_d.footer = 1'b1;
        else if (hits.cl_script) skip_d.script = 1'b0;
        else if (hits.cl_style)  skip_d.style  = 1'b0;
        else if (hits.cl_nav)    skip_d.nav    = 1'b0;
        else if (hits.cl_footer) skip_d.footer = 1'b0;
        else                     skip_d        = skip_c;
      end else begin
        // A line-breaking tag ends: newline unless at start or just after one.
        if (hits.brk && cnt_c != '0 && !pwn_c) begin
          want_emit = 1'b1;
          ch        = hte_pkg::ChNl;
          pws_d     = 1'b1;
        end
        in_tag_d = 1'b0;
        len_d    = '0;
      end
    end else if (|skip_c || b == hte_pkg::ChAmp) begin
      want_emit = 1'b0;
    end else if (b == hte_pkg::ChSp || b == hte_pkg::ChTab || b == hte_pkg::ChNl ||
                 b == hte_pkg::ChCr) begin
      if (!pws_c) begin
        want_emit = 1'b1;
        ch        = hte_pkg::ChSp;
        pws_d     = 1'b1;
      end
    end else begin
      want_emit = 1'b1;
      pws_d     = 1'b0;
    end
    emit_ok = want_emit && can_emit;
    cnt_d   = emit_ok ? cnt_c + 1'b1 : cnt_c;
    pwn_d   = emit_ok ? (ch == hte_pkg::ChNl) : pwn_c;
  end

  assign res_valid_o     = step_i && emit_ok;
  assign res_o.out_char  = ch;
  assign res_o.out_index = cnt_c;
  assign count_o         = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tag_q <= 1'b0;
      len_q    <= '0;
      skip_q   <= '0;
      pws_q    <= 1'b1;
      pwn_q    <= 1'b0;
      cnt_q    <= '0;
    end else if (step_i) begin
      in_tag_q <= in_tag_d;
      len_q    <= len_d;
      skip_q   <= skip_d;
      pws_q    <= pws_d;
      pwn_q    <= pwn_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      pfx_q <= pfx_d;
    end
  end

endmodule

@@ hw/rtl/html_text_extract.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_text_extract
// Streams HTML body bytes in and plain text bytes out.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with in_item_i (byte, new_document).
// Output channel: out_valid_o / out_stall_i with out_item_o (char, index).
// Each input transfer yields zero or one output transfer.
// A byte is captured in an input register, then the parse logic updates
// the parse state and loads the output register when the byte is processed,
// so each result passes through the input register and then the output
// register before its own transfer. One byte per cycle is sustained while
// the receiver does not stall; the parse state feeds back within each step,
// so each step sees the state left by the byte before it.
// When the receiver stalls, the output register holds its byte, the input
// register fills, and in_stall_o rises until the output is taken.
// The configuration port (cfg_we_i, cfg_index_i, cfg_data_i) writes the
// pass-through flag or the output limit; write it only while idle.
// Reset empties both registers, clears the parse state, and loads
// pass-through off and an output limit of 24576.
// ----------------------------------------------------------------------------
module html_text_extract (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  hte_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output hte_pkg::out_item_t                out_item_o,
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_index_i,
  input  logic [hte_pkg::LimitW-1:0]        cfg_data_i
);

  logic                          in_valid_q;
  hte_pkg::in_item_t             in_q;
  logic                          out_valid_q;
  hte_pkg::out_item_t            out_q;
  hte_pkg::cfg_t                 cfg_q;
  logic                          out_ready, fire, res_valid;
  hte_pkg::out_item_t            res;
  logic [hte_pkg::CountW-1:0]    count;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  hte_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (fire),
    .item_i      (in_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .count_o     (count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= res_valid;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.passthrough <= 1'b0;
      cfg_q.limit       <= hte_pkg::LimitReset;
    end else if (cfg_we_i) begin
      unique case (hte_pkg::cfg_idx_e'(cfg_index_i))
        hte_pkg::CfgPassthrough: cfg_q.passthrough <= cfg_data_i[0];
        hte_pkg::CfgOutputLimit: cfg_q.limit       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The input side only stalls behind a full, stalled output register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output");

  // After a byte is emitted, the count stands one above its index.
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res_valid) |=> (count == out_q.out_index + 16'd1))
    else $error("emitted count does not follow the output index");

  // A buffered byte that is not processed stays in the input register.
  a_input_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !fire) |=> in_valid_q)
    else $error("buffered input byte lost");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HTML text extractor. A short table of directed
// bytes runs first, then random documents (text, whitespace, entities, tags
// of every kind, long tags and noise) under several register settings. Each
// accepted byte is run through an independent text predictor, and every
// output transfer is compared with the oldest pending character.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CycleLimit = 600000;
  localparam int PrintCap   = 50;

  typedef struct packed {
    logic [7:0]  data;
    logic        doc;
    logic        typed;
    logic        has;
    logic [7:0]  ch;
    logic [15:0] idx;
  } dir_row_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  hte_pkg::in_item_t          in_item_i   = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  hte_pkg::out_item_t         out_item_o;
  logic                       cfg_we_i    = 1'b0;
  logic [0:0]                 cfg_index_i = hte_pkg::CfgPassthrough;
  logic [hte_pkg::LimitW-1:0] cfg_data_i  = '0;

  // Side information travelling with each input transfer: a typed expectation.
  logic               row_typed = 1'b0;
  logic               row_has   = 1'b0;
  hte_pkg::out_item_t row_want  = '0;

  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;

  // Predictor state.
  logic                       copy_mode;
  logic [hte_pkg::LimitW-1:0] text_limit;
  logic                       inside_markup;
  int                         markup_len;
  logic [7:0]                 markup_head [hte_pkg::MatchPrefixLen];
  logic                       drop_script, drop_style, drop_nav, drop_footer;
  logic                       last_blank, last_lf;
  int unsigned                text_count;

  hte_pkg::out_item_t pending_text [$];
  int unsigned err_count       = 0;
  int unsigned results_checked = 0;
  int unsigned bytes_sent      = 0;
  int unsigned settings_used   = 1;

  logic [7:0] feed_byte [$];
  logic       feed_doc  [$];
  dir_row_t   dir_rows  [26];

  html_text_extract uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic name_hit(input string nm);
    int         n;
    logic [7:0] nx;
    n = nm.len();
    if (n + 2 > hte_pkg::MatchPrefixLen || markup_len < n + 1 ||
        markup_head[0] != hte_pkg::ChLt) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (fold_case(markup_head[i + 1]) != 8'(nm[i])) return 1'b0;
    end
    if (markup_len == n + 1) return 1'b1;
    nx = markup_head[n + 1];
    return nx == hte_pkg::ChSp || nx == hte_pkg::ChGt || nx == hte_pkg::ChSlash;
  endfunction

  function automatic logic put_char(input logic [7:0] ch, output hte_pkg::out_item_t r);
    int unsigned cap;
    cap = (text_limit > hte_pkg::LimitCap) ? 65536 : int'(text_limit);
    r = '0;
    if (text_count + 1 < cap) begin
      r.out_char  = ch;
      r.out_index = 16'(text_count);
      text_count++;
      last_lf = (ch == hte_pkg::ChNl);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic restart_doc();
    inside_markup = 1'b0;
    markup_len    = 0;
    drop_script   = 1'b0;
    drop_style    = 1'b0;
    drop_nav      = 1'b0;
    drop_footer   = 1'b0;
    last_blank    = 1'b1;
    text_count    = 0;
    last_lf       = 1'b0;
  endtask

  task automatic extract_text_step(input logic [7:0] b, input logic nd,
                                   output logic got, output hte_pkg::out_item_t r);
    logic brk;
    got = 1'b0;
    r   = '0;
    if (nd) restart_doc();
    if (copy_mode) begin
      got = put_char(b, r);
    end else if (inside_markup || b == hte_pkg::ChLt) begin
      inside_markup = 1'b1;
      if (markup_len < hte_pkg::TagLenMax) begin
        if (markup_len < hte_pkg::MatchPrefixLen) markup_head[markup_len] = b;
        markup_len++;
      end
      if (b != hte_pkg::ChGt) begin
        // Only the first name that matches takes effect.
        if (name_hit("script")) drop_script = 1'b1;
        else if (name_hit("style")) drop_style = 1'b1;
        else if (name_hit("nav")) drop_nav = 1'b1;
        else if (name_hit("footer")) drop_footer = 1'b1;
        else if (name_hit("/script")) drop_script = 1'b0;
        else if (name_hit("/style")) drop_style = 1'b0;
        else if (name_hit("/nav")) drop_nav = 1'b0;
        else if (name_hit("/footer")) drop_footer = 1'b0;
      end else begin
        brk = name_hit("br") || name_hit("/p") || name_hit("/div") || name_hit("/h1") ||
              name_hit("/h2") || name_hit("/h3") || name_hit("/h4") || name_hit("/li") ||
              name_hit("li") || name_hit("/tr");
        if (brk && text_count > 0 && !last_lf) begin
          got = put_char(hte_pkg::ChNl, r);
          last_blank = 1'b1;
        end
        inside_markup = 1'b0;
        markup_len    = 0;
      end
    end else if (!(drop_script || drop_style || drop_nav || drop_footer) &&
                 b != hte_pkg::ChAmp) begin
      if (b == hte_pkg::ChSp || b == hte_pkg::ChTab || b == hte_pkg::ChNl ||
          b == hte_pkg::ChCr) begin
        if (!last_blank) begin
          got = put_char(hte_pkg::ChSp, r);
          last_blank = 1'b1;
        end
      end else begin
        got = put_char(b, r);
        last_blank = 1'b0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned seen,
                                 input int unsigned want);
    err_count++;
    if (err_count <= PrintCap) begin
      $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, seen, want);
    end
  endtask

  // Input transfers feed the predictor; output transfers are checked in order.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic               got;
    hte_pkg::out_item_t want;
    if (!rst_ni) begin
      copy_mode  = 1'b0;
      text_limit = hte_pkg::LimitReset;
      for (int i = 0; i < hte_pkg::MatchPrefixLen; i++) markup_head[i] = 8'h00;
      restart_doc();
      pending_text.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == hte_pkg::CfgPassthrough) copy_mode = cfg_data_i[0];
        else text_limit = cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) begin
        extract_text_step(in_item_i.in_byte, in_item_i.new_document, got, want);
        if (row_typed) begin
          got  = row_has;
          want = row_want;
        end
        if (got) pending_text.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        results_checked++;
        if (pending_text.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_item_o), 32'd0);
        end else begin
          want = pending_text.pop_front();
          if (out_item_o.out_char !== want.out_char)
            report_mismatch("out_char", 32'(out_item_o.out_char), 32'(want.out_char));
          if (out_item_o.out_index !== want.out_index)
            report_mismatch("out_index", 32'(out_item_o.out_index), 32'(want.out_index));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rx_calm) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 99) < 26);
  end

  // ------------------------------------------------------------------ driving

  task automatic send_byte(input logic [7:0] b, input logic nd, input logic typed,
                           input logic has, input logic [7:0] ch, input logic [15:0] idx);
    hte_pkg::in_item_t  it;
    hte_pkg::out_item_t w;
    it.in_byte      = b;
    it.new_document = nd;
    w.out_char      = ch;
    w.out_index     = idx;
    if (!tx_calm) begin
      while ($urandom_range(0, 99) < 26) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    row_typed  <= typed;
    row_has    <= has;
    row_want   <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Holds the input back until every pending character has come out.
  task automatic settle_output();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_text.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic pt, input logic [hte_pkg::LimitW-1:0] lim);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= hte_pkg::CfgPassthrough;
    cfg_data_i  <= {{(hte_pkg::LimitW - 1){1'b0}}, pt};
    @(posedge clk_i);
    cfg_index_i <= hte_pkg::CfgOutputLimit;
    cfg_data_i  <= lim;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // ---------------------------------------------------------- document builder

  task automatic queue_byte(input logic [7:0] b, input logic nd);
    feed_byte.push_back(b);
    feed_doc.push_back(nd);
  endtask

  task automatic queue_name(input string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = 8'(s[i]);
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
      queue_byte(c, 1'b0);
    end
  endtask

  function automatic string pick_tag_name();
    case ($urandom_range(0, 26))
      0:  return "script";
      1:  return "style";
      2:  return "nav";
      3:  return "footer";
      4:  return "/script";
      5:  return "/style";
      6:  return "/nav";
      7:  return "/footer";
      8:  return "br";
      9:  return "/p";
      10: return "/div";
      11: return "/h1";
      12: return "/h2";
      13: return "/h3";
      14: return "/h4";
      15: return "/li";
      16: return "li";
      17: return "/tr";
      18: return "p";
      19: return "div";
      20: return "span";
      21: return "scripts";
      22: return "/navbar";
      23: return "a";
      24: return "/h5";
      25: return "h1";
      default: return "tr";
    endcase
  endfunction

  function automatic logic [7:0] tag_body_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    return (c == hte_pkg::ChGt) ? "a" : c;
  endfunction

  task automatic queue_fragment();
    int         kind;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      repeat ($urandom_range(1, 8)) begin
        c = 8'($urandom_range(8'h21, 8'h7E));
        queue_byte((c == hte_pkg::ChLt) ? "q" : c, 1'b0);
      end
    end else if (kind < 50) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 3))
          0:       queue_byte(hte_pkg::ChSp, 1'b0);
          1:       queue_byte(hte_pkg::ChTab, 1'b0);
          2:       queue_byte(hte_pkg::ChNl, 1'b0);
          default: queue_byte(hte_pkg::ChCr, 1'b0);
        endcase
      end
    end else if (kind < 82) begin
      queue_byte(hte_pkg::ChLt, 1'b0);
      queue_name(pick_tag_name());
      case ($urandom_range(0, 4))
        0: ;
        1: begin
          queue_byte(hte_pkg::ChSp, 1'b0);
          queue_name("class=x");
        end
        2: queue_byte(hte_pkg::ChSlash, 1'b0);
        3: queue_byte("x", 1'b0);
        default: repeat ($urandom_range(1, 6)) queue_byte(tag_body_byte(), 1'b0);
      endcase
      queue_byte(hte_pkg::ChGt, 1'b0);
    end else if (kind < 88) begin
      queue_byte(hte_pkg::ChAmp, 1'b0);
      queue_name("amp");
      queue_byte(";", 1'b0);
    end else if (kind < 91) begin
      // Can run past the stored length; only the stored prefix decides a match.
      queue_byte(hte_pkg::ChLt, 1'b0);
      queue_name(pick_tag_name());
      queue_byte(hte_pkg::ChSp, 1'b0);
      repeat ($urandom_range(120, 200)) queue_byte(tag_body_byte(), 1'b0);
      queue_byte(hte_pkg::ChGt, 1'b0);
    end else begin
      queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
    end
  endtask

  task automatic run_phase(input logic pt, input logic [hte_pkg::LimitW-1:0] lim,
                           input int total, input int doc_lo, input int doc_hi,
                           input logic calm);
    int doc_end;
    int sent;
    settle_output();
    repeat (6) @(posedge clk_i);
    set_config(pt, lim);
    settings_used++;
    tx_calm <= calm;
    rx_calm <= calm;
    while (feed_byte.size() < total) begin
      doc_end = feed_byte.size() + $urandom_range(doc_lo, doc_hi);
      queue_byte(8'($urandom_range(0, 255)), 1'b1);
      while (feed_byte.size() < doc_end) queue_fragment();
    end
    sent = 0;
    while (sent < total && feed_byte.size() != 0) begin
      if (sent == total / 2) settle_output();
      send_byte(feed_byte.pop_front(), feed_doc.pop_front(), 1'b0, 1'b0, 8'h00, 16'h0000);
      sent++;
    end
    // The tail of the last document is not sent.
    feed_byte.delete();
    feed_doc.delete();
  endtask

  // ----------------------------------------------------------------- sequence

  initial begin
    dir_rows = '{
      '{"A",              1'b1, 1'b1, 1'b1, "A",           16'd0},
      '{hte_pkg::ChTab,   1'b0, 1'b1, 1'b1, hte_pkg::ChSp, 16'd1},
      '{hte_pkg::ChSp,    1'b0, 1'b1, 1'b0, 8'h00,         16'd0},
      '{hte_pkg::ChAmp,   1'b0, 1'b1, 1'b0, 8'h00,         16'd0},
      '{8'hFF,            1'b0, 1'b1, 1'b1, 8'hFF,         16'd2},
      '{8'h00,            1'b0, 1'b1, 1'b1, 8'h00,         16'd3},
      '{hte_pkg::ChLt,    1'b0, 1'b0, 1'b0, 8'h00,         16'd0},
      '{"B",              1'b0, 1'b0, 1'b0, 8'h00,         16'd0},
      '{"r",              1'b0, 1'b0, 1'b0, 8'h00,         16'd0},
      '{hte_pkg::ChGt,    1'b0, 1'b1, 1'b1, hte_pkg::ChNl, 16'd4},
      '{hte_pkg::ChLt,    1'b0, 1'b0, 1'b0, 8'h00,         16'd0},
      '{"n",              1'b0, 1'b0, 1'b0, 8'h00,         16'd0},
      '{"A",              1'b0, 1'b0, 1'b0, 8'h00,         16'd0},
      '{"v",              1'b0, 1'b0, 1'b0, 8'h00,         16'd0},
      '{hte_pkg::ChGt,    1'b0, 1'b0, 1'b0, 8'h00,         16'd0},
      '{"x",              1'b0, 1'b0, 1'b0, 8'h00,         16'd0},
      '{hte_pkg::ChLt,    1'b0, 1'b0, 1'b0, 8'h00,         16'd0},
      '{hte_pkg::ChSlash, 1'b0, 1'b0, 1'b0, 8'h00,         16'd0},
      '{"N",              1'b0, 1'b0, 1'b0, 8'h00,         16'd0},
      '{"a",              1'b0, 1'b0, 1'b0, 8'h00,         16'd0},
      '{"V",              1'b0, 1'b0, 1'b0, 8'h00,         16'd0},
      '{hte_pkg::ChGt,    1'b0, 1'b0, 1'b0, 8'h00,         16'd0},
      '{"z",              1'b0, 1'b0, 1'b0, 8'h00,         16'd0},
      '{hte_pkg::ChCr,    1'b0, 1'b0, 1'b0, 8'h00,         16'd0},
      '{hte_pkg::ChNl,    1'b0, 1'b1, 1'b0, 8'h00,         16'd0},
      '{8'h80,            1'b1, 1'b1, 1'b1, 8'h80,         16'd0}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      send_byte(dir_rows[k].data, dir_rows[k].doc, dir_rows[k].typed, dir_rows[k].has,
                dir_rows[k].ch, dir_rows[k].idx);
    end

    run_phase(1'b0, hte_pkg::LimitReset, 260, 40, 120, 1'b0);
    run_phase(1'b0, hte_pkg::LimitCap,   260, 40, 120, 1'b1);
    run_phase(1'b0, 17'd1,                60, 10,  40, 1'b0);
    run_phase(1'b0, 17'd2,               100,  5,  30, 1'b0);
    run_phase(1'b0, 17'd17,              170, 20,  60, 1'b0);
    run_phase(1'b0, 17'h1FFFF,           200, 40, 120, 1'b0);
    run_phase(1'b1, hte_pkg::LimitReset, 160, 20,  80, 1'b0);
    run_phase(1'b1, 17'd6,                90, 10,  30, 1'b0);
    run_phase(1'b0, 17'd0,                50, 10,  40, 1'b0);
    run_phase(1'b0, 17'd400,             200, 30, 150, 1'b0);

    settle_output();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d input bytes under %0d register settings (pass-through on and off,",
             bytes_sent, settings_used);
    $display("limits 0 to 131071); %0d text bytes compared.", results_checked);
    if (err_count == 0 && pending_text.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timed out after %0d cycles", CycleLimit);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/hte_pkg.sv
hw/rtl/hte_tag_match.sv
hw/rtl/hte_core.sv
hw/rtl/html_text_extract.sv
dv/tb_top.sv
